/* src/sct_pkg.sv */
// Shared types, constants and codes for the symbol table.
`default_nettype none

package sct_pkg;

   localparam int ENTRIES_DEF  = 64;
   localparam int NAME_CHARS   = 6;
   localparam int NAME_W       = NAME_CHARS * 8;
   localparam int ADDR_W       = 15;
   localparam int RES_W        = ADDR_W + 1;
   localparam logic [RES_W-1:0] INDEX_OFFSET = RES_W'(32768);

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_LOOKUP = 1'b1
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_SCAN,
      S_DONE
   } state_type;

   typedef struct packed {
      logic              cmd;
      logic [NAME_W-1:0] symbol_name;
      logic [ADDR_W-1:0] symbol_address;
      logic              indexed;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [RES_W-1:0] result_address;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic       latch_req;
      logic       do_insert;
      logic       rd_en;
      logic       set_res;
      status_type res_status;
      logic       res_found;
      logic       load_rsp;
   } ctl_type;

   // Datapath to controller
   typedef struct packed {
      logic is_insert;
      logic full;
      logic ptr_zero;
      logic match;
   } stat_type;

endpackage

`default_nettype wire

/* src/sct_datapath.sv */
// Entry memory, scan pointer, compare and result registers of the symbol table.
`default_nettype none

module sct_datapath #(
   parameter int ENTRIES = sct_pkg::ENTRIES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sct_pkg::req_type  req_data,
   input  wire sct_pkg::ctl_type  ctl,
   output sct_pkg::stat_type      stat,
   output sct_pkg::rsp_type       rsp_data
);

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   logic [sct_pkg::NAME_W-1:0] name_mem [ENTRIES];
   logic [sct_pkg::ADDR_W-1:0] addr_mem [ENTRIES];

   sct_pkg::req_type           req_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           ptr_ff;
   logic [CNT_W-1:0]           ptr_dec;
   logic [sct_pkg::NAME_W-1:0] rd_name_ff;
   logic [sct_pkg::ADDR_W-1:0] rd_addr_ff;
   logic [1:0]                 res_status_ff;
   logic [sct_pkg::RES_W-1:0]  res_addr_ff, res_addr_in;
   sct_pkg::rsp_type           rsp_ff;

   assign ptr_dec  = ptr_ff - CNT_W'(1);
   assign count_in = ctl.do_insert ? count_ff + CNT_W'(1) : count_ff;

   // Widen the hit address and add the index offset on request
   always_comb begin
      res_addr_in = '0;
      if (ctl.res_found) begin
         res_addr_in = sct_pkg::RES_W'(rd_addr_ff) +
                       (req_ff.indexed ? sct_pkg::INDEX_OFFSET : '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.latch_req) begin
         req_ff <= req_data;
         ptr_ff <= count_ff;
      end else if (ctl.rd_en) begin
         ptr_ff <= ptr_dec;
      end
      if (ctl.set_res) begin
         res_status_ff <= ctl.res_status;
         res_addr_ff   <= res_addr_in;
      end
      if (ctl.load_rsp) begin
         rsp_ff.status         <= res_status_ff;
         rsp_ff.result_address <= res_addr_ff;
      end
   end

   // Single-port entry memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.do_insert) begin
         name_mem[count_ff[IDX_W-1:0]] <= req_ff.symbol_name;
         addr_mem[count_ff[IDX_W-1:0]] <= req_ff.symbol_address;
      end else if (ctl.rd_en) begin
         rd_name_ff <= name_mem[ptr_dec[IDX_W-1:0]];
         rd_addr_ff <= addr_mem[ptr_dec[IDX_W-1:0]];
      end
   end

   assign stat.is_insert = (req_ff.cmd == sct_pkg::CMD_INSERT);
   assign stat.full      = (count_ff == CNT_W'(ENTRIES));
   assign stat.ptr_zero  = (ptr_ff == '0);
   assign stat.match     = (rd_name_ff == req_ff.symbol_name);
   assign rsp_data       = rsp_ff;

endmodule

`default_nettype wire

/* src/sct_ctrl.sv */
// Sequencing state machine and result valid flag of the symbol table.
`default_nettype none

module sct_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   input  wire sct_pkg::stat_type stat,
   output sct_pkg::ctl_type       ctl
);

   sct_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sct_pkg::S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      ctl            = '0;
      ctl.res_status = sct_pkg::ST_OK;
      req_stall      = 1'b1;
      case (state_ff)
         sct_pkg::S_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctl.latch_req = 1'b1;
               state_in      = sct_pkg::S_EXEC;
            end
         end
         sct_pkg::S_EXEC: begin
            if (stat.is_insert) begin
               ctl.set_res = 1'b1;
               if (stat.full) begin
                  ctl.res_status = sct_pkg::ST_FULL;
               end else begin
                  ctl.do_insert = 1'b1;
               end
               state_in = sct_pkg::S_DONE;
            end else if (stat.ptr_zero) begin
               ctl.set_res    = 1'b1;
               ctl.res_status = sct_pkg::ST_NOT_FOUND;
               state_in       = sct_pkg::S_DONE;
            end else begin
               ctl.rd_en = 1'b1;
               state_in  = sct_pkg::S_SCAN;
            end
         end
         sct_pkg::S_SCAN: begin
            if (stat.match) begin
               ctl.set_res   = 1'b1;
               ctl.res_found = 1'b1;
               state_in      = sct_pkg::S_DONE;
            end else if (stat.ptr_zero) begin
               ctl.set_res    = 1'b1;
               ctl.res_status = sct_pkg::ST_NOT_FOUND;
               state_in       = sct_pkg::S_DONE;
            end else begin
               ctl.rd_en = 1'b1;
            end
         end
         sct_pkg::S_DONE: begin
            if (out_free) begin
               ctl.load_rsp = 1'b1;
               state_in     = sct_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sct_pkg::S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (ctl.load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

/* src/symbol_table_cam_core.sv */
// Top level of the assembler symbol table: insert and newest-first lookup.
//
//  channel  ports                            direction  beat holds
//  req      req_valid, req_stall, req_data   in         cmd, name, address, indexed
//  rsp      rsp_valid, rsp_stall, rsp_data   out        status, result address
//
//  An insert or an empty-table lookup goes from accept through EXEC to the
//  result register; a lookup that examines k entries newest first (1 up to
//  the entry count) walks them in SCAN, one entry per cycle from the
//  single-port memory. The next beat can be taken in the cycle after the load.
//  Reset clears the entry count and control state only. A stalled result
//  holds in its output register while the next item runs up to its load.
`default_nettype none

module symbol_table_cam_core #(
   parameter int ENTRIES = sct_pkg::ENTRIES_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   input  wire sct_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output sct_pkg::rsp_type      rsp_data
);

   sct_pkg::ctl_type  ctl;
   sct_pkg::stat_type stat;

   // Sequencer: accepts a beat, walks the entries, hands the result out
   sct_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .ctl       (ctl)
   );

   // Entry store, compare and result registers
   sct_datapath #(
      .ENTRIES (ENTRIES)
   ) u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .ctl      (ctl),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire

/* dv/symbol_table_cam_core_tb.sv */
// Self-checking testbench for the symbol table core: inserts, newest-first lookups, full table.
`timescale 1ns / 100ps

module symbol_table_cam_core_tb;

   localparam int TABLE_DEPTH = sct_pkg::ENTRIES_DEF;
   localparam int HOLD_LEN    = 300;   // cycles of a long receiver hold-off
   localparam int DRAIN_WAIT  = 100;   // settle time after the answers drain, for stray beats to show

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   sct_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   sct_pkg::rsp_type rsp_data;

   // Shadow of the table as the block should hold it
   logic [sct_pkg::NAME_W-1:0] sym_names [TABLE_DEPTH];
   logic [sct_pkg::ADDR_W-1:0] sym_addrs [TABLE_DEPTH];
   int                         sym_count = 0;

   sct_pkg::rsp_type answer_queue [$];
   int               mismatch_count = 0;
   int               send_idle_pct  = 0;
   int               recv_idle_pct  = 0;
   int               hold_requests  = 0;   // raised by the tests
   int               holds_served   = 0;   // owned by the receiver
   int               hold_left      = 0;

   symbol_table_cam_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Update the shadow table and return the answer one beat must produce.
   // The newest match wins, so scan oldest to newest and keep the last hit.
   function automatic sct_pkg::rsp_type predict_symbol_answer(input sct_pkg::req_type beat);
      sct_pkg::rsp_type answer;
      answer = '0;
      if (beat.cmd == sct_pkg::CMD_INSERT) begin
         if (sym_count >= TABLE_DEPTH) begin
            answer.status = sct_pkg::ST_FULL;
         end else begin
            sym_names[sym_count] = beat.symbol_name;
            sym_addrs[sym_count] = beat.symbol_address;
            sym_count++;
            answer.status = sct_pkg::ST_OK;
         end
      end else begin
         answer.status = sct_pkg::ST_NOT_FOUND;
         for (int i = 0; i < sym_count; i++) begin
            if (sym_names[i] == beat.symbol_name) begin
               answer.status = sct_pkg::ST_OK;
               answer.result_address = {1'b0, sym_addrs[i]}
                  + (beat.indexed ? sct_pkg::INDEX_OFFSET : sct_pkg::RES_W'(0));
            end
         end
      end
      return answer;
   endfunction

   function automatic sct_pkg::req_type make_beat(input sct_pkg::cmd_type cmd,
                                                  input logic [sct_pkg::NAME_W-1:0] name,
                                                  input logic [sct_pkg::ADDR_W-1:0] addr,
                                                  input logic indexed);
      sct_pkg::req_type beat;
      beat.cmd            = cmd;
      beat.symbol_name    = name;
      beat.symbol_address = addr;
      beat.indexed        = indexed;
      return beat;
   endfunction

   function automatic logic [sct_pkg::NAME_W-1:0] random_wide_name();
      return {16'($urandom_range(16'hFFFF)), 32'($urandom)};
   endfunction

   // Mostly well-formed assembler traffic: short ASCII labels, duplicates,
   // lookups of stored names; the rest near misses and raw 48-bit noise.
   function automatic sct_pkg::req_type random_symbol_beat();
      sct_pkg::req_type           beat;
      int                         pick;
      int                         len;
      logic [sct_pkg::NAME_W-1:0] name;
      pick = $urandom_range(99);
      beat = make_beat(sct_pkg::CMD_LOOKUP, random_wide_name(), 15'($urandom_range(32767)),
                       1'($urandom_range(1)));
      if (pick < 30) begin
         beat.cmd = sct_pkg::CMD_INSERT;
         case ($urandom_range(3))
            0, 1: begin
               name = '0;
               len  = $urandom_range(sct_pkg::NAME_CHARS, 1);
               for (int c = 0; c < len; c++) begin
                  if (c > 0 && $urandom_range(2) == 0)
                     name[sct_pkg::NAME_W-1-8*c -: 8] = 8'($urandom_range("9", "0"));
                  else
                     name[sct_pkg::NAME_W-1-8*c -: 8] = 8'($urandom_range("Z", "A"));
               end
               beat.symbol_name = name;
            end
            2: begin
               // duplicate label: shadow an older entry
               if (sym_count > 0)
                  beat.symbol_name = sym_names[$urandom_range(sym_count - 1)];
            end
            default: ;
         endcase
      end else if (pick < 80) begin
         if (sym_count > 0)
            beat.symbol_name = sym_names[$urandom_range(sym_count - 1)];
      end else if (pick < 90) begin
         if (sym_count > 0)
            beat.symbol_name = sym_names[$urandom_range(sym_count - 1)]
                               ^ (48'd1 << $urandom_range(sct_pkg::NAME_W - 1));
      end
      return beat;
   endfunction

   // Offer one beat, idling first at random; log the expected answer at accept.
   // Valid stays high after the accept so back-to-back beats need no toggle.
   task automatic send_symbol_beat(input sct_pkg::req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      answer_queue.push_back(predict_symbol_answer(beat));
   endtask

   // Receiver: check each accepted answer, then pick the next stall value.
   always @(posedge clock) begin
      sct_pkg::rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answer_queue.size() == 0) begin
            $display("%0t: unexpected answer, expected none, actual status %0d address %h",
                     $time, rsp_data.status, rsp_data.result_address);
            mismatch_count++;
         end else begin
            want = answer_queue.pop_front();
            if (rsp_data.status !== want.status) begin
               $display("%0t: status mismatch, expected %0d, actual %0d",
                        $time, want.status, rsp_data.status);
               mismatch_count++;
            end
            if (rsp_data.result_address !== want.result_address) begin
               $display("%0t: address mismatch, expected %h, actual %h",
                        $time, want.result_address, rsp_data.result_address);
               mismatch_count++;
            end
         end
      end
      // long hold-off requested by a test: count it down here
      if (hold_requests != holds_served) begin
         holds_served = hold_requests;
         hold_left    = HOLD_LEN;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Lookups into an empty table must miss, indexed or not.
   task automatic test_empty_table();
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '0, '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '1, '1, 1'b1));
   endtask

   // Field extremes, indexed flag on insert, bits past a zero pad byte.
   task automatic test_field_extremes();
      send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, '0, '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, '1, '1, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, {"LOOP", 16'h0000}, 15'h1234, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '0, '1, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '0, '0, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '1, '0, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, '1, '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, {"LOOP", 16'h0000}, '0, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, {"LOOP", 16'h0041}, '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, {"LOOQ", 16'h0000}, '0, 1'b0));
   endtask

   // A second insert of a name hides the first one.
   task automatic test_shadowing();
      send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, "ALPHA1", 15'h0100, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, "ALPHA1", '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, "ALPHA1", 15'h0200, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, "ALPHA1", '0, 1'b0));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, "ALPHA1", '0, 1'b1));
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, "ALPHA0", '0, 1'b1));
   endtask

   task automatic test_random_traffic(input int n_beats, input int send_pct,
                                      input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      repeat (n_beats)
         send_symbol_beat(random_symbol_beat());
   endtask

   // Hold the receiver off while the sender keeps offering, so the result
   // register fills and the block pushes back on its input.
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_requests++;
      repeat (20)
         send_symbol_beat(random_symbol_beat());
   endtask

   // Fill every cell, then drop inserts and scan the full depth.
   task automatic test_table_full();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      while (sym_count < TABLE_DEPTH)
         send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, random_wide_name(),
                                    15'($urandom_range(32767)), 1'($urandom_range(1))));
      for (int i = 0; i < 4; i++) begin
         send_symbol_beat(make_beat(sct_pkg::CMD_INSERT, sym_names[i], '1, 1'b0));
         send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, sym_names[i], '0,
                                    1'($urandom_range(1))));
      end
      send_symbol_beat(make_beat(sct_pkg::CMD_LOOKUP, random_wide_name(), '0, 1'b1));
   endtask

   // Drain outstanding answers, give stray beats time to show, then report.
   task automatic finish_run();
      req_valid <= 1'b0;
      while (answer_queue.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT)
         @(posedge clock);
      if (mismatch_count == 0 && answer_queue.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   endtask

   initial begin
      repeat (8)
         @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send_idle_pct = 33;
      recv_idle_pct = 78;
      test_empty_table();
      test_field_extremes();
      test_shadowing();
      test_random_traffic(120, 33, 78);
      test_random_traffic(120, 78, 33);
      test_backpressure();
      test_table_full();
      test_random_traffic(120, 0, 0);
      finish_run();
   end

   // Watchdog: far beyond the slowest legal run
   initial begin
      #(12 * 400_000);
      $display("TB_ERROR");
      $finish;
   end

endmodule
